### sv/hprl_pkg.sv
// Package for the hashed partition rate limiter: sizes, hash constants,
// job codes of the hash sequencer, and the controller/datapath structs.
// No dependencies.
package hprl_pkg;

  localparam int SLOT_W      = 16;
  localparam int PROBE_DEPTH = 32;

  localparam int TABLE_SIZE = 1 << SLOT_W;
  localparam int SCRUB_SHIFT = 32 - SLOT_W - 1;
  localparam int SCRUB_W    = 32 - SCRUB_SHIFT;
  localparam int PROBE_W    = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
  localparam int ALLOC_W    = 17;

  localparam logic [ALLOC_W-1:0] ALLOC_MAX = '1;

  localparam logic [15:0] WINDOW_RESET = 16'd10000;
  localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(PROBE_DEPTH - 1);

  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_FM1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_FM2  = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_ADD1 = 64'h0000000052dce729;
  localparam logic [63:0] MM_ADD2 = 64'h0000000038495ab5;
  localparam logic [63:0] MM_LEN  = 64'd20;

  // one job = one 64x64 low-half multiply by a constant plus its post step
  typedef enum logic [3:0] {
    JOB_K1A = 4'd0,
    JOB_K1B = 4'd1,
    JOB_K2A = 4'd2,
    JOB_K2B = 4'd3,
    JOB_K3A = 4'd4,
    JOB_K3B = 4'd5,
    JOB_F1A = 4'd6,
    JOB_F1B = 4'd7,
    JOB_F2A = 4'd8,
    JOB_F2B = 4'd9
  } job_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic prep;
    logic hash;
    logic rd;
    logic eval;
    logic upd;
    logic scrub;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_tick;
    logic tick_idle;
    logic hash_done;
    logic hit;
    logic miss;
    logic scrub_done;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] times5(input logic [63:0] x);
    return x + (x << 2);
  endfunction

  function automatic logic [63:0] job_mult(input job_t j);
    logic [63:0] c;
    case (j)
      JOB_K1A, JOB_K2B, JOB_K3A: c = MM_C1;
      JOB_K1B, JOB_K2A, JOB_K3B: c = MM_C2;
      JOB_F1A, JOB_F2A:          c = MM_FM1;
      JOB_F1B, JOB_F2B:          c = MM_FM2;
      default:                   c = MM_C1;
    endcase
    return c;
  endfunction

endpackage

### sv/hprl_ifs.sv
// Channel interfaces: request words in, response words out.
// Does not use hprl_pkg; plain widths only.
interface hprl_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] token;
  logic [63:0] label_generation;
  logic [31:0] label_value;
  logic [31:0] op_limit;
  modport source (output valid, command, token, label_generation, label_value, op_limit,
                  input ready);
  modport sink (input valid, command, token, label_generation, label_value, op_limit,
                output ready);
endinterface

interface hprl_rsp_if;
  logic        valid;
  logic        ready;
  logic        admit;
  logic        tracked;
  logic [63:0] label_generation_out;
  logic [31:0] label_value_out;
  modport source (output valid, admit, tracked, label_generation_out, label_value_out,
                  input ready);
  modport sink (input valid, admit, tracked, label_generation_out, label_value_out,
                output ready);
endinterface

### sv/hprl_hash.sv
// Iterative MurmurHash3 x64_128 (seed 0) over token, label, generation.
// One 32x32 multiplier, reused over the phases of each 64-bit constant multiply. Uses hprl_pkg.
module hprl_hash import hprl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       tok,
  input  logic [31:0]       lab,
  input  logic [63:0]       gen,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  logic [63:0] x_r, acc_r, h1_r, h2_r;
  job_t        job_r;
  logic [1:0]  ph_r;
  logic        busy_r, adj_r, done_r;
  logic [SLOT_W-1:0] slot_r;

  logic [63:0] c, p, fm;
  logic [31:0] a, b;

  assign c  = job_mult(job_r);
  assign a  = (ph_r == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign b  = (ph_r == 2'd1) ? c[63:32] : c[31:0];
  assign p  = {32'd0, a} * {32'd0, b};
  assign fm = acc_r ^ (acc_r >> 33);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      adj_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= tok;
        job_r  <= JOB_K1A;
        ph_r   <= 2'd0;
        busy_r <= 1'b1;
        adj_r  <= 1'b0;
      end else if (busy_r) begin
        if (adj_r) begin
          // h2 += h1, then first fmix step of h1
          h2_r  <= h2_r + h1_r;
          x_r   <= h1_r ^ (h1_r >> 33);
          adj_r <= 1'b0;
        end else begin
          case (ph_r)
            2'd0: begin
              acc_r <= p;
              ph_r  <= 2'd1;
            end
            2'd1: begin
              acc_r <= acc_r + {p[31:0], 32'd0};
              ph_r  <= 2'd2;
            end
            2'd2: begin
              acc_r <= acc_r + {p[31:0], 32'd0};
              ph_r  <= 2'd3;
            end
            default: begin
              ph_r  <= 2'd0;
              job_r <= job_t'(job_r + 4'd1);
              case (job_r)
                JOB_K1A: x_r <= rotl64(acc_r, 31);
                JOB_K1B: begin
                  h1_r <= times5(rotl64(acc_r, 27)) + MM_ADD1;
                  x_r  <= {gen[31:0], lab};
                end
                JOB_K2A: x_r <= rotl64(acc_r, 33);
                JOB_K2B: begin
                  h2_r <= rotl64(acc_r, 31) + h1_r;
                  x_r  <= {32'd0, gen[63:32]};
                end
                JOB_K3A: begin
                  x_r  <= rotl64(acc_r, 31);
                  h2_r <= times5(h2_r) + MM_ADD2;
                end
                JOB_K3B: begin
                  h1_r  <= (h1_r ^ acc_r ^ MM_LEN) + (h2_r ^ MM_LEN);
                  h2_r  <= h2_r ^ MM_LEN;
                  adj_r <= 1'b1;
                end
                JOB_F1A: x_r <= fm;
                JOB_F1B: begin
                  h1_r <= fm;
                  x_r  <= h2_r ^ (h2_r >> 33);
                end
                JOB_F2A: x_r <= fm;
                JOB_F2B: begin
                  slot_r <= h1_r[SLOT_W-1:0] + fm[SLOT_W-1:0];
                  done_r <= 1'b1;
                  busy_r <= 1'b0;
                end
                default: ;
              endcase
            end
          endcase
        end
      end
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

### sv/hprl_ctrl.sv
// Controller state machine: sequences clear, hash, probes, update, scrub, result.
// Uses hprl_pkg for cmd_t/sts_t.
module hprl_ctrl import hprl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t st,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_HASH  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_EVAL  = 9'b000100000,
    S_UPD   = 9'b001000000,
    S_SCRUB = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (!st.is_tick)       state_nxt = S_HASH;
        else if (st.tick_idle) state_nxt = S_FIN;
        else                   state_nxt = S_SCRUB;
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (st.hash_done) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.hit)       state_nxt = S_UPD;
        else if (st.miss) state_nxt = S_FIN;
        else              state_nxt = S_RD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_SCRUB: begin
        cmd.scrub = 1'b1;
        if (st.scrub_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = st.out_free;
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

### sv/hprl_dp.sv
// Datapath: bucket memories, global counters, probe logic, output register.
// Uses hprl_pkg and instantiates hprl_hash.
module hprl_dp import hprl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        st,
  input  logic        in_command,
  input  logic [63:0] in_token,
  input  logic [63:0] in_lgen,
  input  logic [31:0] in_lval,
  input  logic [31:0] in_limit,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_admit,
  output logic        out_tracked,
  output logic [63:0] out_lgen,
  output logic [31:0] out_lval
);

  logic [63:0] tok_mem [TABLE_SIZE];
  logic [31:0] lab_mem [TABLE_SIZE];
  logic [31:0] cnt_mem [TABLE_SIZE];
  logic [63:0] rd_tok_r;
  logic [31:0] rd_lab_r, rd_cnt_r;

  // item registers
  logic        tick_r;
  logic [63:0] tok_r, lgen_r;
  logic [31:0] lab_r, limit_r;
  logic [SLOT_W-1:0]  slot_r, cand_r, found_r;
  logic [PROBE_W-1:0] i_r;
  logic        hc_r, admit_r, tracked_r;
  logic [31:0] base_r;

  // global state
  logic [31:0] decay_r, first_r, next_r;
  logic [15:0] ops_r, wops_r;
  logic [ALLOC_W-1:0] alloc_r;
  logic [63:0] gen_r;
  logic [SCRUB_W-1:0] si_r;
  logic [SLOT_W-1:0]  clr_r;

  logic        ov_r, adm_o_r, trk_o_r;
  logic [63:0] lgen_o_r;
  logic [31:0] lval_o_r;

  logic              h_done;
  logic [SLOT_W-1:0] h_slot;

  hprl_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.prep & ~tick_r),
    .tok   (tok_r),
    .lab   (lab_r),
    .gen   (gen_r),
    .done  (h_done),
    .slot  (h_slot)
  );

  // probe evaluation
  logic e, x, m, last, hc_eff, tl_we, sdone, ok;
  logic [SLOT_W-1:0] cand_eff;
  logic [31:0] cnt, cnt_new;
  logic [15:0] ops_inc;

  assign e        = (rd_lab_r - first_r) >= (next_r - first_r);
  assign x        = ~e & (rd_cnt_r <= decay_r);
  assign m        = ~e & ~x & (rd_tok_r == tok_r) & (rd_lab_r == lab_r);
  assign last     = (i_r == LAST_PROBE);
  assign hc_eff   = hc_r | x;
  assign cand_eff = hc_r ? cand_r : slot_r;
  assign tl_we    = cmd.eval & (e | (m & hc_r) | (~e & ~m & last & hc_eff));
  assign sdone    = (si_r == next_r[31:SCRUB_SHIFT]);
  assign cnt      = base_r - decay_r;
  assign ok       = (cnt + 32'd1) <= limit_r;
  assign cnt_new  = ok ? base_r + 32'd1 : base_r;
  assign ops_inc  = ops_r + 16'd1;

  always_comb begin
    st            = '0;
    st.clr_last   = (clr_r == '1);
    st.is_tick    = tick_r;
    st.tick_idle  = (alloc_r == '0);
    st.hash_done  = h_done;
    st.hit        = e | m | (last & hc_eff);
    st.miss       = last & ~e & ~m & ~hc_eff;
    st.scrub_done = sdone;
    st.out_free   = ~ov_r | out_ready;
  end

  // memories
  logic              tw, lw, cw;
  logic [SLOT_W-1:0] ta, la, ca;
  logic [63:0]       td;
  logic [31:0]       ld, cd;

  always_comb begin
    tw = cmd.clr | tl_we;
    ta = cmd.clr ? clr_r : cand_eff;
    td = cmd.clr ? 64'd0 : tok_r;
    lw = cmd.clr | tl_we | (cmd.scrub & ~sdone);
    la = cmd.clr ? clr_r : (cmd.scrub ? si_r[SLOT_W-1:0] : cand_eff);
    ld = cmd.clr ? 32'd0 : (cmd.scrub ? next_r - 32'd1 : lab_r);
    cw = cmd.clr | (cmd.eval & m & hc_r) | cmd.upd;
    ca = cmd.clr ? clr_r : (cmd.upd ? found_r : slot_r);
    cd = cmd.upd ? cnt_new : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (tw) tok_mem[ta] <= td;
    if (cmd.rd) rd_tok_r <= tok_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (lw) lab_mem[la] <= ld;
    if (cmd.rd) rd_lab_r <= lab_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cw) cnt_mem[ca] <= cd;
    if (cmd.rd) rd_cnt_r <= cnt_mem[slot_r];
  end

  // global state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= '0;
      ops_r   <= '0;
      alloc_r <= '0;
      first_r <= '0;
      next_r  <= '0;
      gen_r   <= '0;
      wops_r  <= WINDOW_RESET;
      clr_r   <= '0;
    end else begin
      if (cfg_we) wops_r <= cfg_wdata;
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.prep) begin
        if (tick_r) begin
          if (alloc_r != '0) begin
            decay_r <= '0;
            alloc_r <= '0;
            ops_r   <= '0;
          end
        end else if (lgen_r != gen_r) begin
          next_r <= next_r + 32'd1;
        end
      end
      if (cmd.eval & e & ~hc_r & (alloc_r != ALLOC_MAX)) alloc_r <= alloc_r + 1'b1;
      if (cmd.upd & ok) begin
        if (ops_inc == wops_r) begin
          decay_r <= decay_r + 32'd1;
          ops_r   <= '0;
        end else begin
          ops_r <= ops_inc;
        end
      end
      if (cmd.scrub & sdone) begin
        first_r <= next_r;
        gen_r   <= gen_r + 64'd1;
      end
    end
  end

  // per-item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r  <= in_command;
      tok_r   <= in_token;
      lgen_r  <= in_lgen;
      lab_r   <= in_lval;
      limit_r <= in_limit;
    end
    if (cmd.prep) begin
      admit_r   <= ~tick_r;
      tracked_r <= 1'b0;
      si_r      <= first_r[31:SCRUB_SHIFT];
      if (~tick_r & (lgen_r != gen_r)) begin
        lgen_r <= gen_r;
        lab_r  <= next_r;
      end
    end
    if (cmd.hash & h_done) begin
      slot_r <= h_slot;
      i_r    <= '0;
      hc_r   <= 1'b0;
    end
    if (cmd.eval) begin
      if (st.hit) begin
        tracked_r <= 1'b1;
        found_r   <= (m & ~hc_r) ? slot_r : cand_eff;
        base_r    <= m ? rd_cnt_r : decay_r;
      end else begin
        hc_r   <= hc_eff;
        cand_r <= cand_eff;
        i_r    <= i_r + 1'b1;
        slot_r <= slot_r + SLOT_W'(i_r) + 1'b1;
      end
    end
    if (cmd.upd) admit_r <= ok;
    if (cmd.scrub & ~sdone) si_r <= si_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.fin) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      adm_o_r  <= admit_r;
      trk_o_r  <= tracked_r;
      lgen_o_r <= lgen_r;
      lval_o_r <= lab_r;
    end
  end

  assign out_valid   = ov_r;
  assign out_admit   = adm_o_r;
  assign out_tracked = trk_o_r;
  assign out_lgen    = lgen_o_r;
  assign out_lval    = lval_o_r;

endmodule

### sv/hashed_partition_rate_limiter.sv
// Top level of the hashed partition rate limiter: controller plus datapath.
// Depends on hprl_pkg, hprl_ifs, hprl_ctrl, hprl_dp (which holds hprl_hash).
//
//  channel   | dir | handshake      | word
//  ----------+-----+----------------+-----------------------------------------------
//  in_chan   | in  | valid/ready    | command, token, label_generation, label_value,
//            |     |                | op_limit
//  out_chan  | out | valid/ready    | admit, tracked, label_generation_out,
//            |     |                | label_value_out
//  cfg_*     | in  | cfg_we         | cfg_wdata = window_ops
//
// Operation: accept, prep, hash (one shared 32x32 multiplier, reused over the
//   phases of each 64-bit multiply), then per bucket probe a memory read and an
//   evaluation (1..32 probes), then update and result load; a miss runs all
//   32 probes and skips the update.
// Tick: when idle, straight to the result load; else the stale label rows are scrubbed first.
// Reset: synchronous, active low; then a clearing pass over all 65536 bucket rows
//   with in_chan.ready low. cfg writes are taken at any time except during reset.
// Stalls: the next word is accepted while a result waits in the output register;
//   only the result load waits on out_chan.ready.
module hashed_partition_rate_limiter import hprl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hprl_req_if.sink    in_chan,
  hprl_rsp_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cmd_t cmd;
  sts_t st;

  // controller: one-hot sequencer, in_ready only when idle
  hprl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: bucket tables, counters, hash unit, result register
  hprl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_command  (in_chan.command),
    .in_token    (in_chan.token),
    .in_lgen     (in_chan.label_generation),
    .in_lval     (in_chan.label_value),
    .in_limit    (in_chan.op_limit),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_admit   (out_chan.admit),
    .out_tracked (out_chan.tracked),
    .out_lgen    (out_chan.label_generation_out),
    .out_lval    (out_chan.label_value_out)
  );

`ifndef ASSERT_OFF
  // one word in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("accepted a word while one is in flight");

  // hash completion only seen while the controller waits for it
  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.hash_done |-> cmd.hash)
    else $error("hash done outside hash wait");

  // a new result appears only after a result load
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.fin))
    else $error("result valid without a load");
`endif

endmodule

### tb/hashed_partition_rate_limiter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for hashed_partition_rate_limiter: random and directed words,
// a behavioral predictor of the bucket table, and an in-order response checker.
// Depends on hprl_ifs (channel interfaces) and the RTL top level.
module hashed_partition_rate_limiter_test;

  localparam int TBL      = 65536;
  localparam int N_CALLER = 8;

  typedef struct {
    logic        command;
    logic [63:0] token;
    logic [63:0] lgen;
    logic [31:0] lval;
    logic [31:0] limit;
    int          caller;   // -1: not tied to a caller's label
  } req_t;

  typedef struct {
    logic        admit;
    logic        tracked;
    logic [63:0] lgen;
    logic [31:0] lval;
  } verdict_t;

  typedef struct {
    logic [63:0] token;
    logic [63:0] lgen;
    logic [31:0] lval;
    logic [31:0] limit;
  } caller_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  hprl_req_if in_if ();
  hprl_rsp_if out_if ();

  hashed_partition_rate_limiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- shadow table
  logic [63:0] tok_mem [TBL];
  logic [31:0] lab_mem [TBL];
  logic [31:0] cnt_mem [TBL];
  logic [31:0] decay_win;
  logic [15:0] win_ops_seen;
  logic [16:0] allocs;
  logic [31:0] first_lab;
  logic [31:0] next_lab;
  logic [63:0] cur_gen;
  logic [15:0] window_ops;

  caller_t  callers [N_CALLER];
  req_t     pend [$];        // words waiting for the driver
  verdict_t verdicts [$];    // expected response words, oldest first

  int n_err = 0, n_ops = 0, n_ticks = 0, n_admit = 0, n_reject = 0, n_untracked = 0;
  int n_rsp = 0;

  function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] mix_final(input logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> 33);
    k = k * 64'hc4ceb9fe1a85ec53;
    k = k ^ (k >> 33);
    return k;
  endfunction

  // first 64-bit half of the 128-bit digest over the 20-byte key, seed 0
  function automatic logic [63:0] bucket_hash(input logic [63:0] tok, input logic [31:0] lab,
                                              input logic [63:0] gen);
    logic [63:0] c1, c2, h1, h2, k1, k2;
    c1 = 64'h87c37b91114253d5;
    c2 = 64'h4cf5ad432745937f;
    h1 = 64'd0;
    h2 = 64'd0;
    k1 = tok;
    k2 = {gen[31:0], lab};
    k1 = k1 * c1; k1 = rol64(k1, 31); k1 = k1 * c2; h1 = h1 ^ k1;
    h1 = rol64(h1, 27); h1 = h1 + h2; h1 = h1 * 64'd5 + 64'h52dce729;
    k2 = k2 * c2; k2 = rol64(k2, 33); k2 = k2 * c1; h2 = h2 ^ k2;
    h2 = rol64(h2, 31); h2 = h2 + h1; h2 = h2 * 64'd5 + 64'h38495ab5;
    k1 = {32'd0, gen[63:32]};
    k1 = k1 * c1; k1 = rol64(k1, 31); k1 = k1 * c2; h1 = h1 ^ k1;
    h1 = h1 ^ 64'd20; h2 = h2 ^ 64'd20;
    h1 = h1 + h2; h2 = h2 + h1;
    h1 = mix_final(h1); h2 = mix_final(h2);
    return h1 + h2;
  endfunction

  function automatic logic slot_free(input logic [15:0] s);
    logic [31:0] a, b;
    a = lab_mem[s] - first_lab;
    b = next_lab - first_lab;
    return a >= b;
  endfunction

  function automatic void slot_claim(input logic [15:0] s, input logic [63:0] tok,
                                     input logic [31:0] lab);
    tok_mem[s] = tok;
    lab_mem[s] = lab;
    cnt_mem[s] = decay_win;
  endfunction

  // find or allocate the bucket; relocates a live entry into an earlier expired slot
  function automatic logic locate_bucket(input logic [31:0] lab, input logic [63:0] tok,
                                         output logic [15:0] hit);
    logic [63:0] h;
    logic [15:0] slot, cand;
    logic have_cand;
    h = bucket_hash(tok, lab, cur_gen);
    slot = h[15:0];
    cand = 16'd0;
    have_cand = 1'b0;
    hit = 16'd0;
    for (int i = 0; i < 32; i++) begin
      slot = slot + 16'(i);
      if (slot_free(slot)) begin
        if (!have_cand) begin
          if (allocs != 17'h1FFFF) allocs = allocs + 17'd1;
          slot_claim(slot, tok, lab);
          hit = slot;
        end else begin
          slot_claim(cand, tok, lab);
          hit = cand;
        end
        return 1'b1;
      end else if (cnt_mem[slot] <= decay_win) begin
        if (!have_cand) begin
          have_cand = 1'b1;
          cand = slot;
        end
      end else if (tok_mem[slot] == tok && lab_mem[slot] == lab) begin
        if (have_cand) begin
          tok_mem[cand] = tok_mem[slot];
          lab_mem[cand] = lab_mem[slot];
          cnt_mem[cand] = cnt_mem[slot];
          cnt_mem[slot] = 32'd0;
          hit = cand;
        end else begin
          hit = slot;
        end
        return 1'b1;
      end
    end
    if (have_cand) begin
      slot_claim(cand, tok, lab);
      hit = cand;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // new generation plus scrub of stale label rows; nothing if no allocation happened
  function automatic void start_generation();
    logic [16:0] row, stop;
    if (allocs == 17'd0) return;
    decay_win = 32'd0;
    allocs = 17'd0;
    win_ops_seen = 16'd0;
    row = first_lab[31:15];
    stop = next_lab[31:15];
    while (row != stop) begin
      lab_mem[row[15:0]] = next_lab - 32'd1;
      row = row + 17'd1;
    end
    first_lab = next_lab;
    cur_gen = cur_gen + 64'd1;
  endfunction

  function automatic verdict_t admit_verdict(input req_t r);
    verdict_t v;
    logic [15:0] s;
    logic [31:0] cnt, cnt1;
    v.admit = 1'b1;
    v.tracked = 1'b0;
    v.lgen = r.lgen;
    v.lval = r.lval;
    if (r.command) begin
      start_generation();
      v.admit = 1'b0;
      return v;
    end
    if (v.lgen != cur_gen) begin
      v.lgen = cur_gen;
      v.lval = next_lab;
      next_lab = next_lab + 32'd1;
    end
    if (locate_bucket(v.lval, r.token, s)) begin
      v.tracked = 1'b1;
      cnt = cnt_mem[s] - decay_win;
      cnt1 = cnt + 32'd1;
      if (cnt1 <= r.limit) begin
        cnt_mem[s] = cnt_mem[s] + 32'd1;
        win_ops_seen = win_ops_seen + 16'd1;
        if (win_ops_seen == window_ops) begin
          decay_win = decay_win + 32'd1;
          win_ops_seen = 16'd0;
        end
      end else begin
        v.admit = 1'b0;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- driver
  req_t cur;
  int   send_gap = 0;
  logic send_hold = 1'b0;   // sender pause
  logic calm = 1'b0;        // no idling in the closing part

  initial begin
    in_if.valid = 1'b0;
    in_if.command = 1'b0;
    in_if.token = 64'd0;
    in_if.label_generation = 64'd0;
    in_if.label_value = 32'd0;
    in_if.op_limit = 32'd0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        v = admit_verdict(cur);
        verdicts.push_back(v);
        if (cur.command) n_ticks++;
        else n_ops++;
        // a well-behaved caller keeps the refreshed label
        if (!cur.command && cur.caller >= 0 && callers[cur.caller].token == cur.token) begin
          callers[cur.caller].lgen = v.lgen;
          callers[cur.caller].lval = v.lval;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pend.size() > 0 && !send_hold) begin
          cur = pend.pop_front();
          in_if.valid <= 1'b1;
          in_if.command <= cur.command;
          in_if.token <= cur.token;
          in_if.label_generation <= cur.lgen;
          in_if.label_value <= cur.lval;
          in_if.op_limit <= cur.limit;
          if (!calm && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int   rx_gap = 0;
  logic long_hold_go = 1'b0;
  logic long_hold_done = 1'b0;
  int   long_hold_cnt = 0;

  // long back-pressure stretch, timed here
  always @(posedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      if (long_hold_cnt == 1500) long_hold_done <= 1'b1;
      else long_hold_cnt <= long_hold_cnt + 1;
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_rsp++;
        if (verdicts.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected response word at %0t", $realtime);
        end else begin
          e = verdicts.pop_front();
          if (out_if.admit !== e.admit || out_if.tracked !== e.tracked ||
              out_if.label_generation_out !== e.lgen || out_if.label_value_out !== e.lval) begin
            n_err++;
            if (n_err <= 10) begin
              $write("mismatch word %0d: exp adm=%b trk=%b gen=%h lab=%h",
                     n_rsp, e.admit, e.tracked, e.lgen, e.lval);
              $display(", got adm=%b trk=%b gen=%h lab=%h", out_if.admit,
                       out_if.tracked, out_if.label_generation_out, out_if.label_value_out);
            end
          end else if (!e.admit && e.tracked) n_reject++;
          else if (e.admit && !e.tracked) n_untracked++;
          else if (e.admit) n_admit++;
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFFFFFF;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic req_t caller_op(input int c);
    req_t r;
    r.command = 1'b0;
    r.token = callers[c].token;
    r.lgen = callers[c].lgen;
    r.lval = callers[c].lval;
    r.limit = callers[c].limit;
    r.caller = c;
    return r;
  endfunction

  function automatic req_t mk_req(input logic cmd, input logic [63:0] tok,
                                  input logic [63:0] g, input logic [31:0] l,
                                  input logic [31:0] lim);
    req_t r;
    r.command = cmd;
    r.token = tok;
    r.lgen = g;
    r.lval = l;
    r.limit = lim;
    r.caller = -1;
    return r;
  endfunction

  task automatic push_req(input req_t r);
    while (pend.size() >= 2) @(posedge clk);
    pend.push_back(r);
  endtask

  // random words: mostly callers that carry their labels forward, some ticks, some noise
  task automatic push_random(input int n);
    int c, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      c = $urandom_range(0, N_CALLER - 1);
      if (k < 6) begin
        push_req(mk_req(1'b1, rnd64(), rnd64(), $urandom(), $urandom()));
      end else if (k < 16) begin
        push_req(mk_req(1'($urandom_range(0, 1)), rnd64(), rnd64(), $urandom(), $urandom()));
      end else begin
        if ($urandom_range(0, 40) == 0) begin
          callers[c].token = rnd64();
          callers[c].limit = pick_limit();
        end
        push_req(caller_op(c));
      end
    end
  endtask

  task automatic drain();
    while (pend.size() > 0 || in_if.valid || verdicts.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ops = w;
  endtask

  logic [15:0] win_plan [6] = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd10000, 16'd5};

  initial begin
    for (int i = 0; i < TBL; i++) begin
      tok_mem[i] = 64'd0;
      lab_mem[i] = 32'd0;
      cnt_mem[i] = 32'd0;
    end
    decay_win = 32'd0;
    win_ops_seen = 16'd0;
    allocs = 17'd0;
    first_lab = 32'd0;
    next_lab = 32'd0;
    cur_gen = 64'd0;
    window_ops = 16'd10000;
    for (int c = 0; c < N_CALLER; c++) begin
      callers[c].token = (c < 4) ? 64'(c) : rnd64();
      callers[c].lgen = 64'hFFFFFFFFFFFFFFFF;   // stale on first use
      callers[c].lval = 32'd0;
      callers[c].limit = 32'(c % 4 + 1);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, field extremes, zero and full limits, label refresh
    push_req(mk_req(1'b1, 64'd0, 64'd0, 32'd0, 32'd0));
    push_req(mk_req(1'b1, '1, '1, '1, '1));
    push_req(mk_req(1'b0, 64'd0, 64'd0, 32'd0, 32'd0));
    push_req(mk_req(1'b0, 64'd0, 64'd0, 32'd0, 32'd1));
    push_req(mk_req(1'b0, 64'd0, 64'd0, 32'd0, 32'd1));
    push_req(mk_req(1'b0, '1, '1, '1, '1));
    push_req(mk_req(1'b0, '1, 64'd0, '1, '1));
    push_req(mk_req(1'b0, 64'h5555555555555555, 64'd0, 32'hAAAAAAAA, 32'd2));
    push_req(mk_req(1'b0, 64'hAAAAAAAAAAAAAAAA, 64'd0, 32'h55555555, 32'd2));
    push_req(mk_req(1'b1, 64'd0, 64'd0, 32'd0, 32'd0));
    push_req(mk_req(1'b0, 64'd0, 64'd0, 32'd0, 32'd1));
    push_req(mk_req(1'b0, 64'd0, 64'd1, 32'd0, 32'd1));
    push_req(mk_req(1'b1, 64'd0, 64'd0, 32'd0, 32'd0));
    for (int c = 0; c < N_CALLER; c++) push_req(caller_op(c));
    drain();

    for (int p = 0; p < 6; p++) begin
      set_window(win_plan[p]);
      if (p == 1) begin
        push_random(40);
        long_hold_go <= 1'b1;   // receiver blocks, sender keeps offering
        push_random(110);
      end else if (p == 5) begin
        push_random(30);
        // sender pause until every response is back
        while (pend.size() > 0) @(posedge clk);
        send_hold <= 1'b1;
        while (in_if.valid || verdicts.size() > 0) @(posedge clk);
        send_hold <= 1'b0;
        push_random(30);
        while (pend.size() > 0) @(posedge clk);
        calm <= 1'b1;
        push_random(130);
      end else begin
        push_random(150);
      end
      drain();
    end

    $display("covered %0d account words and %0d ticks over 6 window settings", n_ops, n_ticks);
    $display("admitted %0d, rejected %0d, untracked %0d", n_admit, n_reject, n_untracked);
    if (n_err == 0 && verdicts.size() == 0) begin
      $display("hashed_partition_rate_limiter regression: pass");
    end else begin
      $display("%0d mismatches", n_err);
      $display("hashed_partition_rate_limiter regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d responses outstanding", verdicts.size());
    $display("hashed_partition_rate_limiter regression: fail");
    $finish;
  end

endmodule

### sim.f
sv/hprl_pkg.sv
sv/hprl_ifs.sv
sv/hprl_hash.sv
sv/hprl_ctrl.sv
sv/hprl_dp.sv
sv/hashed_partition_rate_limiter.sv
tb/hashed_partition_rate_limiter_test.sv
